@@ rtl/lrap_pkg.sv @@
// lrap_pkg: types, character codes and register indexes of the line range parser
// used by every rtl file of line_range_address_parser and by its checker
package lrap_pkg;

   localparam int LINE_BITS = 32;
   localparam int CH_BITS   = 8;
   localparam int IDX_BITS  = 16;
   localparam int CSR_IDX_BITS = 4;
   localparam int RSP_BITS  = 2 * LINE_BITS + IDX_BITS;

   typedef logic [LINE_BITS-1:0]    line_type;
   typedef logic [CH_BITS-1:0]      ch_type;
   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam ch_type CH_NUL    = 8'h00;
   localparam ch_type CH_SPACE  = 8'h20;
   localparam ch_type CH_DOLLAR = 8'h24;
   localparam ch_type CH_PCT    = 8'h25;
   localparam ch_type CH_PLUS   = 8'h2B;
   localparam ch_type CH_COMMA  = 8'h2C;
   localparam ch_type CH_MINUS  = 8'h2D;
   localparam ch_type CH_DOT    = 8'h2E;
   localparam ch_type CH_ZERO   = 8'h30;
   localparam ch_type CH_NINE   = 8'h39;

   localparam csr_idx_type CSR_DOT_LINE   = 4'd0;
   localparam csr_idx_type CSR_LINE_COUNT = 4'd1;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_ADDR,
      PH_NUM,
      PH_BASE,
      PH_OFF,
      PH_AFTER_BEG,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      SLOT_BEG,
      SLOT_LEAD_COMMA,
      SLOT_ADDR_COMMA
   } slot_type;

   typedef struct packed {
      line_type dot_line;
      line_type line_count;
   } cfg_type;

   typedef struct packed {
      logic   valid;
      ch_type ch;
   } item_type;

   typedef struct packed {
      idx_type  chars_used;
      line_type last_line;
      line_type first_line;
   } result_type;

endpackage

@@ rtl/line_range_address_parser.sv @@
// line_range_address_parser: top level of the editor line range parser
// depends on lrap_pkg, lrap_csr, lrap_in_stage, lrap_parse_core, lrap_out_stage
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata[7:0] ch
//   rsp     | out | rsp_tvalid/rsp_tready | tdata[31:0] first_line, [63:32] last_line,
//           |     |                       |   [79:64] chars_used
//   csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata
//
// one character per cycle, but a nul stalls while the result register is full; a result
// leaves through the input register and then the result register after its nul transaction
// reset is synchronous and clears control state and the csr registers only, no clearing pass
// a nul waits in the input register while the result register is full and rsp_tready is low
module line_range_address_parser
   import lrap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // ch
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // first_line, last_line, chars_used
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_idx_type         csr_index,
   input  line_type            csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   logic       advance;
   logic       out_free;
   logic       res_valid;
   result_type res;

   assign advance = item.valid && ((item.ch != CH_NUL) || out_free);

   lrap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lrap_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   lrap_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .ch        (item.ch),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   lrap_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/lrap_csr.sv @@
// lrap_csr: dot_line and line_count registers behind the csr write channel
// depends on lrap_pkg
module lrap_csr
   import lrap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  line_type    csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DOT_LINE: begin
               cfg_in.dot_line = csr_wdata;
            end
            CSR_LINE_COUNT: begin
               cfg_in.line_count = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

@@ rtl/lrap_in_stage.sv @@
// lrap_in_stage: input register for one character transaction
// depends on lrap_pkg
module lrap_in_stage
   import lrap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  ch_type   req_tdata,
   input  logic     advance,
   output item_type item
);

   logic   valid_ff;
   logic   valid_in;
   ch_type ch_ff;
   ch_type ch_in;
   logic   accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      ch_in    = ch_ff;
      if (accept) begin
         valid_in = 1'b1;
         ch_in    = req_tdata;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   assign item = '{valid: valid_ff, ch: ch_ff};

endmodule

@@ rtl/lrap_parse_core.sv @@
// lrap_parse_core: parser state machine, digit accumulator and offset arithmetic
// depends on lrap_pkg
module lrap_parse_core
   import lrap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  ch_type     ch,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   phase_type  phase_ff, phase_in;
   slot_type   slot_ff, slot_in;
   idx_type    idx_ff, idx_in;
   line_type   num_ff, num_in;
   line_type   off_ff, off_in;
   logic       neg_ff, neg_in;
   logic       digits_ff, digits_in;
   logic       ovf_ff, ovf_in;
   line_type   start_ff, start_in;
   line_type   base_ff, base_in;
   idx_type    bend_ff, bend_in;
   idx_type    astart_ff, astart_in;
   result_type res_ff, res_in;

   logic       fin;
   result_type fin_res;

   logic       is_digit, is_sign;
   idx_type    idx_inc;
   line_type   acc_src;
   logic [LINE_BITS+3:0] acc10;
   logic       acc_ovf;
   line_type   off_one;
   logic [LINE_BITS:0] off_sum;
   logic       off_ok;
   line_type   off_val;

   function automatic result_type addr_fail(slot_type s, line_type st, idx_type used,
                                            cfg_type c);
      result_type r;
      r.chars_used = used;
      unique case (s)
         SLOT_LEAD_COMMA: begin
            r.first_line = st;
            r.last_line  = c.dot_line;
         end
         SLOT_ADDR_COMMA: begin
            r.first_line = st;
            r.last_line  = c.line_count;
         end
         default: begin
            r.first_line = c.dot_line;
            r.last_line  = c.dot_line;
         end
      endcase
      return r;
   endfunction

   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign idx_inc  = (idx_ff == '1) ? idx_ff : idx_ff + 1'b1;

   // acc * 10 + digit, shared by the number and the offset
   assign acc_src = (phase_ff == PH_OFF) ? off_ff : num_ff;
   assign acc10   = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}
                  + {{LINE_BITS{1'b0}}, ch[3:0]};
   assign acc_ovf = ovf_ff || (|acc10[LINE_BITS+3:LINE_BITS]);

   assign off_one = digits_ff ? off_ff : LINE_BITS'(1);
   assign off_sum = {1'b0, base_ff} + {1'b0, off_one};
   assign off_ok  = !ovf_ff && (neg_ff ? (off_one <= base_ff) : !off_sum[LINE_BITS]);
   assign off_val = neg_ff ? base_ff - off_one : off_sum[LINE_BITS-1:0];

   always_comb begin : next_state
      phase_type ph;
      slot_type  sl;
      line_type  st;
      idx_type   as_w;
      line_type  bs;
      logic      ok_go;
      line_type  ok_val;

      ph     = phase_ff;
      sl     = slot_ff;
      st     = start_ff;
      as_w   = astart_ff;
      bs     = base_ff;
      ok_go  = 1'b0;
      ok_val = '0;

      phase_in  = phase_ff;
      slot_in   = slot_ff;
      num_in    = num_ff;
      off_in    = off_ff;
      neg_in    = neg_ff;
      digits_in = digits_ff;
      ovf_in    = ovf_ff;
      start_in  = start_ff;
      base_in   = base_ff;
      bend_in   = bend_ff;
      astart_in = astart_ff;
      fin       = 1'b0;
      fin_res   = '0;

      if (ph == PH_LEAD) begin
         priority if (ch == CH_SPACE) begin
            phase_in = PH_LEAD;
         end else if (ch == CH_NUL) begin
            fin      = 1'b1;
            fin_res  = '{chars_used: idx_ff, last_line: cfg.dot_line,
                         first_line: cfg.dot_line};
            phase_in = PH_DONE;
         end else if (ch == CH_PCT) begin
            fin      = 1'b1;
            fin_res  = '{chars_used: idx_inc, last_line: cfg.line_count,
                         first_line: LINE_BITS'(1)};
            phase_in = PH_DONE;
         end else if (ch == CH_COMMA) begin
            start_in  = cfg.dot_line;
            slot_in   = SLOT_LEAD_COMMA;
            astart_in = idx_inc;
            phase_in  = PH_ADDR;
         end else begin
            sl        = SLOT_BEG;
            slot_in   = SLOT_BEG;
            as_w      = idx_ff;
            astart_in = idx_ff;
            ph        = PH_ADDR;
         end
      end

      if (ph == PH_ADDR) begin
         priority if ((ch == CH_DOT) || (ch == CH_DOLLAR)) begin
            base_in  = (ch == CH_DOT) ? cfg.dot_line : cfg.line_count;
            bend_in  = idx_inc;
            phase_in = PH_BASE;
         end else if (is_sign) begin
            base_in   = cfg.dot_line;
            bend_in   = idx_ff;
            neg_in    = (ch == CH_MINUS);
            off_in    = '0;
            digits_in = 1'b0;
            ovf_in    = 1'b0;
            phase_in  = PH_OFF;
         end else if (is_digit) begin
            num_in   = {{(LINE_BITS-4){1'b0}}, ch[3:0]};
            ovf_in   = 1'b0;
            phase_in = PH_NUM;
         end else begin
            fin      = 1'b1;
            fin_res  = addr_fail(sl, st, as_w, cfg);
            phase_in = PH_DONE;
         end
      end

      if (ph == PH_NUM) begin
         priority if (is_digit) begin
            ovf_in = acc_ovf;
            if (!acc_ovf) begin
               num_in = acc10[LINE_BITS-1:0];
            end
         end else if (ovf_ff) begin
            fin      = 1'b1;
            fin_res  = addr_fail(sl, st, as_w, cfg);
            phase_in = PH_DONE;
         end else begin
            bs      = num_ff;
            base_in = num_ff;
            bend_in = idx_ff;
            ph      = PH_BASE;
         end
      end

      if (ph == PH_BASE) begin
         if (is_sign) begin
            neg_in    = (ch == CH_MINUS);
            off_in    = '0;
            digits_in = 1'b0;
            ovf_in    = 1'b0;
            phase_in  = PH_OFF;
         end else begin
            ok_go  = 1'b1;
            ok_val = bs;
         end
      end

      if (ph == PH_OFF) begin
         priority if (is_digit) begin
            ovf_in    = acc_ovf;
            digits_in = 1'b1;
            if (!acc_ovf) begin
               off_in = acc10[LINE_BITS-1:0];
            end
         end else if (off_ok) begin
            ok_go  = 1'b1;
            ok_val = off_val;
         end else begin
            // failed offset keeps the base address
            fin      = 1'b1;
            fin_res  = '{chars_used: bend_ff, last_line: base_ff,
                         first_line: (sl == SLOT_BEG) ? base_ff : st};
            phase_in = PH_DONE;
         end
      end

      if (ok_go) begin
         if (sl == SLOT_BEG) begin
            st       = ok_val;
            start_in = ok_val;
            ph       = PH_AFTER_BEG;
         end else begin
            fin      = 1'b1;
            fin_res  = '{chars_used: idx_ff, last_line: ok_val, first_line: st};
            phase_in = PH_DONE;
         end
      end

      if (ph == PH_AFTER_BEG) begin
         priority if (ch == CH_SPACE) begin
            phase_in = PH_AFTER_BEG;
         end else if (ch == CH_COMMA) begin
            slot_in   = SLOT_ADDR_COMMA;
            astart_in = idx_inc;
            phase_in  = PH_ADDR;
         end else begin
            fin      = 1'b1;
            fin_res  = '{chars_used: idx_ff, last_line: st, first_line: st};
            phase_in = PH_DONE;
         end
      end

      // end of text rearms the parser
      if (ch == CH_NUL) begin
         phase_in = PH_LEAD;
         slot_in  = SLOT_BEG;
         idx_in   = '0;
      end else begin
         idx_in = idx_inc;
      end
   end

   always_comb begin : outputs
      res_in    = fin ? fin_res : res_ff;
      res       = (phase_ff == PH_DONE) ? res_ff : fin_res;
      res_valid = step && (ch == CH_NUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         slot_ff  <= SLOT_BEG;
         idx_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         num_ff    <= num_in;
         off_ff    <= off_in;
         neg_ff    <= neg_in;
         digits_ff <= digits_in;
         ovf_ff    <= ovf_in;
         start_ff  <= start_in;
         base_ff   <= base_in;
         bend_ff   <= bend_in;
         astart_ff <= astart_in;
         res_ff    <= res_in;
      end
   end

endmodule

@@ rtl/lrap_out_stage.sv @@
// lrap_out_stage: result register on the rsp side
// depends on lrap_pkg
module lrap_out_stage
   import lrap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  result_type          res,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.chars_used, res_ff.last_line, res_ff.first_line};

endmodule

@@ rtl/lrap_checker.sv @@
// lrap_checker: port level checks of line_range_address_parser, with its bind
// depends on lrap_pkg and the top level ports
module lrap_checker
   import lrap_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [7:0]          req_tdata,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       nul_acc;
   logic       rsp_acc;

   // nul transactions taken whose result has not left yet
   assign nul_acc    = req_tvalid && req_tready && (req_tdata == CH_NUL);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign pending_in = 2'(pending_ff + {1'b0, nul_acc} - {1'b0, rsp_acc});

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_rsp_has_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result without a nul transaction");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two texts in flight");

endmodule

bind line_range_address_parser lrap_checker u_lrap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/lrap_range_checker.sv @@
// lrap_range_checker: watches the req, rsp and csr channels of line_range_address_parser,
// predicts the range of every text that a nul ends and compares it with the rsp transaction
// depends on lrap_pkg
module lrap_range_checker
   import lrap_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,   // ch
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_BITS-1:0] rsp_tdata,   // first_line, last_line, chars_used
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  csr_idx_type         csr_index,
   input  line_type            csr_wdata,
   output int                  errors,
   output int                  outstanding
);

   localparam line_type    LINE_MAX = '1;
   localparam int unsigned IDX_MAX  = 65535;

   line_type    cur_line, num_lines;
   phase_type   ph;
   slot_type    sl;
   line_type    num_acc, off_acc, start_val, base_val, res_first, res_last;
   logic        off_neg, digits_seen, ovf;
   int unsigned ch_idx, stop_idx, base_end, addr_start;
   result_type  expected_ranges[$];
   int          mismatches = 0;

   function automatic void rearm();
      ph = PH_LEAD;
      sl = SLOT_BEG;
      num_acc = '0;
      off_acc = '0;
      start_val = '0;
      base_val = '0;
      res_first = '0;
      res_last = '0;
      off_neg = 1'b0;
      digits_seen = 1'b0;
      ovf = 1'b0;
      ch_idx = 0;
      stop_idx = 0;
      base_end = 0;
      addr_start = 0;
   endfunction

   function automatic logic is_digit(ch_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic void end_parse(line_type f, line_type l, int unsigned used);
      res_first = f;
      res_last = l;
      stop_idx = (used > IDX_MAX) ? IDX_MAX : used;
      ph = PH_DONE;
   endfunction

   function automatic void add_digit(inout line_type acc, input ch_type c);
      line_type d;
      d = line_type'(c - CH_ZERO);
      if (ovf || acc > (LINE_MAX - d) / 10) ovf = 1'b1;
      else acc = acc * 10 + d;
   endfunction

   function automatic void start_offset(ch_type c);
      off_neg = (c == CH_MINUS);
      off_acc = '0;
      digits_seen = 1'b0;
      ovf = 1'b0;
      ph = PH_OFF;
   endfunction

   function automatic void addr_good(line_type v);
      if (sl == SLOT_BEG) begin
         start_val = v;
         ph = PH_AFTER_BEG;
      end else begin
         end_parse(start_val, v, ch_idx);
      end
   endfunction

   function automatic void addr_bad();
      if (sl == SLOT_BEG) end_parse(cur_line, cur_line, addr_start);
      else if (sl == SLOT_LEAD_COMMA) end_parse(start_val, cur_line, addr_start);
      else end_parse(start_val, num_lines, addr_start);
   endfunction

   function automatic void parse_char(ch_type c);
      logic     again;
      logic     ok;
      line_type off, b;
      again = 1'b1;
      while (again && ph != PH_DONE) begin
         again = 1'b0;
         case (ph)
            PH_LEAD: begin
               if (c == CH_SPACE) begin
               end else if (c == CH_NUL) begin
                  end_parse(cur_line, cur_line, ch_idx);
               end else if (c == CH_PCT) begin
                  end_parse(line_type'(1), num_lines, ch_idx + 1);
               end else if (c == CH_COMMA) begin
                  start_val = cur_line;
                  sl = SLOT_LEAD_COMMA;
                  addr_start = ch_idx + 1;
                  ph = PH_ADDR;
               end else begin
                  sl = SLOT_BEG;
                  addr_start = ch_idx;
                  ph = PH_ADDR;
                  again = 1'b1;
               end
            end
            PH_ADDR: begin
               if (c == CH_DOT || c == CH_DOLLAR) begin
                  base_val = (c == CH_DOT) ? cur_line : num_lines;
                  base_end = ch_idx + 1;
                  ph = PH_BASE;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  base_val = cur_line;
                  base_end = ch_idx;
                  start_offset(c);
               end else if (is_digit(c)) begin
                  num_acc = line_type'(c - CH_ZERO);
                  ovf = 1'b0;
                  ph = PH_NUM;
               end else begin
                  addr_bad();
               end
            end
            PH_NUM: begin
               if (is_digit(c)) begin
                  add_digit(num_acc, c);
               end else if (ovf) begin
                  addr_bad();
               end else begin
                  base_val = num_acc;
                  base_end = ch_idx;
                  ph = PH_BASE;
                  again = 1'b1;
               end
            end
            PH_BASE: begin
               if (c == CH_PLUS || c == CH_MINUS) begin
                  start_offset(c);
               end else begin
                  addr_good(base_val);
                  again = 1'b1;
               end
            end
            PH_OFF: begin
               if (is_digit(c)) begin
                  add_digit(off_acc, c);
                  digits_seen = 1'b1;
               end else begin
                  off = digits_seen ? off_acc : line_type'(1);
                  b = base_val;
                  if (ovf) ok = 1'b0;
                  else if (off_neg) ok = (off <= b);
                  else ok = (off <= LINE_MAX - b);
                  if (ok) begin
                     addr_good(off_neg ? b - off : b + off);
                     again = 1'b1;
                  end else if (sl == SLOT_BEG) begin
                     end_parse(b, b, base_end);
                  end else begin
                     end_parse(start_val, b, base_end);
                  end
               end
            end
            PH_AFTER_BEG: begin
               if (c == CH_SPACE) begin
               end else if (c == CH_COMMA) begin
                  sl = SLOT_ADDR_COMMA;
                  addr_start = ch_idx + 1;
                  ph = PH_ADDR;
               end else begin
                  end_parse(start_val, start_val, ch_idx);
               end
            end
            default: end_parse(cur_line, cur_line, ch_idx);
         endcase
      end
   endfunction

   function automatic void take_char(ch_type c);
      result_type r;
      if (ph != PH_DONE) parse_char(c);
      if (c != CH_NUL) begin
         if (ch_idx < IDX_MAX) ch_idx++;
      end else begin
         r.first_line = res_first;
         r.last_line  = res_last;
         r.chars_used = idx_type'(stop_idx);
         expected_ranges.push_back(r);
         rearm();
      end
   endfunction

   function automatic void report(string what, logic [LINE_BITS-1:0] want,
                                  logic [LINE_BITS-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("lrap_range_checker: %s expected %0d got %0d", what, want, got);
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         cur_line = '0;
         num_lines = '0;
         expected_ranges.delete();
         rearm();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DOT_LINE:   cur_line = csr_wdata;
               CSR_LINE_COUNT: num_lines = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata);
            if (expected_ranges.size() == 0) begin
               report("unexpected transaction, first_line", '0, got.first_line);
            end else begin
               want = expected_ranges.pop_front();
               if (got.first_line !== want.first_line)
                  report("first_line", want.first_line, got.first_line);
               if (got.last_line !== want.last_line)
                  report("last_line", want.last_line, got.last_line);
               if (got.chars_used !== want.chars_used)
                  report("chars_used", LINE_BITS'(want.chars_used),
                         LINE_BITS'(got.chars_used));
            end
         end
         if (req_tvalid && req_tready) take_char(req_tdata);
      end
      errors <= mismatches;
      outstanding <= expected_ranges.size();
   end

endmodule

@@ tb/sv/line_range_address_parser_tb.sv @@
// line_range_address_parser_tb: drives range texts and register writes into
// line_range_address_parser and gives the verdict
// depends on lrap_pkg, lrap_range_checker and the rtl of the block
module line_range_address_parser_tb;
   import lrap_pkg::*;

   localparam int CYCLE_LIMIT  = 40000;
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_CYCLES = 300;
   localparam int PHASE_ITEMS  = 186;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_idx_type         csr_index = CSR_DOT_LINE;
   line_type            csr_wdata = '0;

   logic   gaps_on = 1'b1;
   int     hold_asks = 0;
   int     cycles = 0;
   int     items_sent = 0;
   int     errors;
   int     outstanding;
   ch_type text_q[$];

   string directed_texts[] = '{"", "   ", "%", "  % junk", ".", "$", "5", "5,9",
      "  12 ,  3 tail", ",7", ",", ",x", "3,", "3,x", "x", "4294967295", "4294967296",
      "5+", "5-3", ".+2", "$-1", "-", "+4", "1-5", "4294967295+1", "+99999999999", "7 x"};

   line_range_address_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lrap_range_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("line_range_address_parser_tb: errors");
         $finish;
      end
   end

   // result side: random back-pressure plus long hold-offs on request
   initial begin : sink
      int stall_left = 0;
      int holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 27);
         end
      end
   end

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(ch_type'(s[i]));
   endfunction

   function automatic void put_spaces(int n);
      repeat (n) text_q.push_back(CH_SPACE);
   endfunction

   function automatic void put_junk(int n);
      string pool;
      pool = " ,.$+-0123456789%x";
      repeat (n) begin
         if ($urandom_range(0, 1)) text_q.push_back(ch_type'(pool[$urandom_range(0, 17)]));
         else text_q.push_back(ch_type'($urandom_range(1, 255)));
      end
   endfunction

   function automatic string rand_number();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $sformatf("%0d", $urandom_range(0, 30));
         4:          return $sformatf("%0d", 32'hFFFF_FFFF - $urandom_range(0, 3));
         5:          return $sformatf("%0d", 64'd4294967296 + $urandom_range(0, 100000));
         6:          return {"00", $sformatf("%0d", $urandom_range(0, 9))};
         7:          return "99999999999";
         default:    return $sformatf("%0d", $urandom());
      endcase
   endfunction

   function automatic void put_offset();
      put_str($urandom_range(0, 1) ? "+" : "-");
      if ($urandom_range(0, 3) != 0) put_str(rand_number());
   endfunction

   function automatic void put_addr();
      case ($urandom_range(0, 7))
         0: put_str(".");
         1: put_str("$");
         2: begin
            put_offset();
            return;
         end
         3: begin
            put_junk(1);
            return;
         end
         default: put_str(rand_number());
      endcase
      if ($urandom_range(0, 1)) put_offset();
   endfunction

   // mostly well-formed ranges with random addresses, the rest noise
   function automatic void make_text();
      int form;
      put_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      form = $urandom_range(0, 99);
      if (form < 5) begin
      end else if (form < 10) begin
         put_str("%");
      end else if (form < 18) begin
         put_str(",");
         if ($urandom_range(0, 3) != 0) put_addr();
      end else if (form < 42) begin
         put_addr();
      end else if (form < 72) begin
         put_addr();
         put_spaces($urandom_range(0, 2));
         put_str(",");
         put_addr();
      end else if (form < 82) begin
         put_addr();
         put_str(",");
      end else if (form < 90) begin
         put_addr();
         put_spaces($urandom_range(0, 2));
         put_str(",");
         put_junk(1);
      end else begin
         put_junk($urandom_range(1, 8));
      end
      if ($urandom_range(0, 2) == 0) put_junk($urandom_range(1, 4));
   endfunction

   task automatic send_char(input ch_type c);
      while (gaps_on && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_char(text_q[i]);
      send_char(CH_NUL);
      text_q.delete();
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input line_type cur, input line_type cnt);
      wait_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_DOT_LINE;
      csr_wdata <= cur;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_LINE_COUNT;
      csr_wdata <= cnt;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text();
      put_str(".$");
      send_text();
      reconfigure(32'd7, 32'd20);
      foreach (directed_texts[i]) begin
         put_str(directed_texts[i]);
         send_text();
      end
      text_q.push_back(8'hFF);
      text_q.push_back(8'h80);
      send_text();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: reconfigure(32'd1, 32'd1);
            1: reconfigure('1, '1);
            2: reconfigure('0, '0);
            3: reconfigure(32'hFFFF_FFFE, '1);
            4: reconfigure($urandom(), $urandom());
            5: reconfigure(32'd12, 32'd40);
            6: reconfigure('1, '0);
            default: reconfigure($urandom_range(0, 100), $urandom());
         endcase
         if (p == 3) gaps_on <= 1'b0;
         if (p == 2 || p == 5) hold_asks <= hold_asks + 1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            make_text();
            send_text();
         end
         gaps_on <= 1'b1;
      end

      wait_results();
      if (errors == 0 && outstanding == 0) begin
         $display("line_range_address_parser_tb: clean");
      end else begin
         $display("line_range_address_parser_tb: errors");
      end
      $finish;
   end

endmodule
